// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside of reset
`define DBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also applies while reset is held
`define DBF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/dbf_pkg.sv =====
`default_nettype none

package dbf_pkg;

  // end of the value range and the release margin beyond the deadzone
  localparam logic [6:0] TOP_VALUE      = 7'd127;
  localparam logic [6:0] RELEASE_MARGIN = 7'd2;
  localparam logic [5:0] MIN_DEADZONE   = 6'd1;

  // register reset values
  localparam logic [5:0] DEADZONE_RESET = 6'd1;
  localparam logic       SNAP_RESET     = 1'b1;

  // item actions
  typedef enum logic [0:0] {
    ACT_FILTER = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DEADZONE = 1'b0,
    CFG_SNAP     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e    action;
    logic [6:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [6:0] filtered_value;
    logic       value_changed;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/deadband_filter_endpoint_snap.sv =====
// channel | direction | handshake            | word
// in      | input     | in_valid_i/in_stall_o | dbf_pkg::in_t  (action, sample_value)
// out     | output    | out_valid_o/out_stall_i | dbf_pkg::out_t (filtered_value, value_changed)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle sustained while the output is not stalled; an accepted word passes
// the input register, then filter logic into the result register, before it shows at the output
// rst_ni clears the pipeline valids, held value and end flags and sets the registers to their reset values at once
// in_stall_o rises only while the input register is full and the result is stalled
// cfg_ready_o is always high; a write takes effect at the next edge
`default_nettype none

module deadband_filter_endpoint_snap (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dbf_pkg::in_t     in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dbf_pkg::out_t         out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire dbf_pkg::cfg_idx_e cfg_index_i,
  input  wire logic [5:0]       cfg_data_i
);

  logic          in_valid_q;
  dbf_pkg::in_t  in_data_q;
  logic          out_valid_q;
  dbf_pkg::out_t out_data_q;
  dbf_pkg::out_t out_data_d;

  logic [5:0] deadzone_q;
  logic [5:0] deadzone_d;
  logic       snap_q;
  logic       snap_d;
  logic [6:0] held_q;
  logic [6:0] held_d;
  logic       bottom_q;
  logic       bottom_d;
  logic       top_q;
  logic       top_d;

  logic       out_ready;
  logic       step;
  logic       cfg_we;
  logic [5:0] eff_dz;
  logic [6:0] eff_dz_w;
  logic [6:0] release_thr;
  logic [6:0] top_release;
  logic [6:0] top_snap;
  logic [6:0] sample;
  logic [6:0] delta;

  // handshake
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign step        = in_valid_q && out_ready;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // thresholds
  assign eff_dz      = (deadzone_q == 6'd0) ? dbf_pkg::MIN_DEADZONE : deadzone_q;
  assign eff_dz_w    = {1'b0, eff_dz};
  assign release_thr = eff_dz_w + dbf_pkg::RELEASE_MARGIN;
  assign top_release = dbf_pkg::TOP_VALUE - release_thr;
  assign top_snap    = dbf_pkg::TOP_VALUE - eff_dz_w;
  assign sample      = in_data_q.sample_value;
  assign delta       = (sample >= held_q) ? (sample - held_q) : (held_q - sample);

  // filter decision and state update
  always_comb begin
    out_data_d.filtered_value = held_q;
    out_data_d.value_changed  = 1'b0;
    held_d     = held_q;
    bottom_d   = bottom_q;
    top_d      = top_q;
    deadzone_d = deadzone_q;
    snap_d     = snap_q;

    if (in_data_q.action == dbf_pkg::ACT_CLEAR) begin
      out_data_d.filtered_value = 7'd0;
    end else if (snap_q && bottom_q) begin
      if (sample >= release_thr) begin
        out_data_d.filtered_value = sample;
        out_data_d.value_changed  = 1'b1;
      end else begin
        out_data_d.filtered_value = 7'd0;
        out_data_d.value_changed  = (held_q != 7'd0);
      end
    end else if (snap_q && top_q) begin
      if (sample <= top_release) begin
        out_data_d.filtered_value = sample;
        out_data_d.value_changed  = 1'b1;
      end else begin
        out_data_d.filtered_value = dbf_pkg::TOP_VALUE;
        out_data_d.value_changed  = (held_q != dbf_pkg::TOP_VALUE);
      end
    end else if (snap_q && (sample <= eff_dz_w)) begin
      out_data_d.filtered_value = 7'd0;
      out_data_d.value_changed  = (held_q != 7'd0);
    end else if (snap_q && (sample >= top_snap)) begin
      out_data_d.filtered_value = dbf_pkg::TOP_VALUE;
      out_data_d.value_changed  = (held_q != dbf_pkg::TOP_VALUE);
    end else if (delta >= eff_dz_w) begin
      out_data_d.filtered_value = sample;
      out_data_d.value_changed  = 1'b1;
    end

    if (step) begin
      // held value always ends up equal to the delivered value
      held_d = out_data_d.filtered_value;
      if (in_data_q.action == dbf_pkg::ACT_CLEAR) begin
        bottom_d = 1'b0;
        top_d    = 1'b0;
      end else if (snap_q && bottom_q) begin
        bottom_d = (sample >= release_thr) ? 1'b0 : 1'b1;
      end else if (snap_q && top_q) begin
        top_d = (sample <= top_release) ? 1'b0 : 1'b1;
      end else if (snap_q && (sample <= eff_dz_w)) begin
        bottom_d = 1'b1;
      end else if (snap_q && (sample >= top_snap)) begin
        top_d = 1'b1;
      end
    end

    // register writes
    if (cfg_we) begin
      case (cfg_index_i)
        dbf_pkg::CFG_DEADZONE: begin
          deadzone_d = cfg_data_i;
        end
        dbf_pkg::CFG_SNAP: begin
          snap_d = cfg_data_i[0];
          if (!cfg_data_i[0]) begin
            bottom_d = 1'b0;
            top_d    = 1'b0;
          end
        end
        default: begin
          deadzone_d = deadzone_q;
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      deadzone_q  <= dbf_pkg::DEADZONE_RESET;
      snap_q      <= dbf_pkg::SNAP_RESET;
      held_q      <= 7'd0;
      bottom_q    <= 1'b0;
      top_q       <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      deadzone_q <= deadzone_d;
      snap_q     <= snap_d;
      held_q     <= held_d;
      bottom_q   <= bottom_d;
      top_q      <= top_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dbf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dbf_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire dbf_pkg::out_t     out_data_o
);

  // while reset is held, no result word follows
  `DBF_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "output valid after reset")

  // a stalled result word holds
  `DBF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output changed")

  // an accepted word is followed by a valid result word at the output
  `DBF_ASSERT(a_in_to_out, in_valid_i && !in_stall_o |=> ##1 out_valid_o, "accepted word lost")

  // input stalls only behind a stalled result
  `DBF_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output stall")

endmodule

bind deadband_filter_endpoint_snap dbf_checker u_dbf_checker (.*);

`default_nettype wire

// ===== bench/tb_deadband_filter_endpoint_snap.sv =====
`timescale 1ns / 1ps

module tb_deadband_filter_endpoint_snap;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 150;
  localparam int PHASE_COUNT = 12;

  // tracks the filter state and the results still owed by the block
  class deadband_tracker;
    logic [5:0]    deadzone;
    logic          snap_on;
    logic [6:0]    held;
    logic          at_bottom;
    logic          at_top;
    dbf_pkg::out_t pending[$];
    int            errors;

    function new();
      deadzone  = dbf_pkg::DEADZONE_RESET;
      snap_on   = dbf_pkg::SNAP_RESET;
      held      = '0;
      at_bottom = 1'b0;
      at_top    = 1'b0;
      errors    = 0;
    endfunction

    // register write as the block applies it
    function void write_reg(dbf_pkg::cfg_idx_e idx, logic [5:0] data);
      case (idx)
        dbf_pkg::CFG_DEADZONE: deadzone = data;
        dbf_pkg::CFG_SNAP: begin
          snap_on = data[0];
          if (!snap_on) begin
            at_bottom = 1'b0;
            at_top    = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function logic [6:0] eff_deadzone();
      return (deadzone == 6'd0) ? {1'b0, dbf_pkg::MIN_DEADZONE} : {1'b0, deadzone};
    endfunction

    // accepted input word: compute the filtered result it must produce
    function void note_sample(dbf_pkg::in_t w);
      logic [6:0]    dz;
      logic [6:0]    rel;
      logic [6:0]    s;
      logic [6:0]    res;
      logic [6:0]    gap;
      logic          chg;
      dbf_pkg::out_t r;
      dz  = eff_deadzone();
      rel = dz + dbf_pkg::RELEASE_MARGIN;
      s   = w.sample_value;
      res = s;
      chg = 1'b0;
      if (w.action == dbf_pkg::ACT_CLEAR) begin
        held      = '0;
        at_bottom = 1'b0;
        at_top    = 1'b0;
        res       = '0;
      end else begin
        if (snap_on && at_bottom) begin
          if (s >= rel) begin
            at_bottom = 1'b0;
            chg       = 1'b1;
          end else begin
            res = '0;
            chg = (held != 7'd0);
          end
        end else if (snap_on && at_top) begin
          if (s <= dbf_pkg::TOP_VALUE - rel) begin
            at_top = 1'b0;
            chg    = 1'b1;
          end else begin
            res = dbf_pkg::TOP_VALUE;
            chg = (held != dbf_pkg::TOP_VALUE);
          end
        end else if (snap_on && s <= dz) begin
          at_bottom = 1'b1;
          res       = '0;
          chg       = (held != 7'd0);
        end else if (snap_on && s >= dbf_pkg::TOP_VALUE - dz) begin
          at_top = 1'b1;
          res    = dbf_pkg::TOP_VALUE;
          chg    = (held != dbf_pkg::TOP_VALUE);
        end else begin
          gap = (s >= held) ? s - held : held - s;
          if (gap >= dz) begin
            chg = 1'b1;
          end else begin
            res = held;
          end
        end
        if (chg) held = res;
      end
      r.filtered_value = res;
      r.value_changed  = chg;
      pending.push_back(r);
    endfunction

    // accepted output word against the oldest expectation
    function void check_result(dbf_pkg::out_t got);
      dbf_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d changed %0b",
                 $time, got.filtered_value, got.value_changed);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.filtered_value !== want.filtered_value) begin
          $display("%0t: filtered_value expected %0d actual %0d",
                   $time, want.filtered_value, got.filtered_value);
          errors++;
        end
        if (got.value_changed !== want.value_changed) begin
          $display("%0t: value_changed expected %0b actual %0b",
                   $time, want.value_changed, got.value_changed);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  dbf_pkg::in_t      in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  dbf_pkg::out_t     out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  dbf_pkg::cfg_idx_e cfg_index_i = dbf_pkg::CFG_DEADZONE;
  logic [5:0]        cfg_data_i  = '0;

  deadband_tracker tracker = new();
  bit quiet  = 1'b0;
  int cycles = 0;

  deadband_filter_endpoint_snap u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random output stall, none in quiet stretches
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 25);
  end

  // signals are settled mid-cycle; a word seen here is taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
  end

  // present one input word, at random with a gap ahead of it outside quiet stretches
  task automatic push_sample(dbf_pkg::action_e a, int s);
    dbf_pkg::in_t w;
    bit           taken;
    w.action       = a;
    w.sample_value = s[6:0];
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.note_sample(w);
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(dbf_pkg::cfg_idx_e idx, logic [5:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // samples biased toward the ends and toward the held value
  function automatic int pick_sample();
    int dz;
    int v;
    dz = tracker.eff_deadzone();
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 127);
      1: v = $urandom_range(0, (dz + 4 > 127) ? 127 : dz + 4);
      2: v = $urandom_range((123 - dz < 0) ? 0 : 123 - dz, 127);
      default: begin
        v = tracker.held + $urandom_range(0, 2 * dz + 4) - (dz + 2);
        if (v < 0) v = 0;
        if (v > 127) v = 127;
      end
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_deadzone();
    case ($urandom_range(0, 5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd63;
      default: return 6'($urandom_range(1, 62));
    endcase
  endfunction

  initial begin
    logic [5:0] snap_data;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default setup: both ends, release, deadzone pass and hold, clear
    push_sample(dbf_pkg::ACT_FILTER, 0);
    push_sample(dbf_pkg::ACT_FILTER, 2);
    push_sample(dbf_pkg::ACT_FILTER, 3);
    push_sample(dbf_pkg::ACT_FILTER, 4);
    push_sample(dbf_pkg::ACT_FILTER, 127);
    push_sample(dbf_pkg::ACT_FILTER, 125);
    push_sample(dbf_pkg::ACT_FILTER, 124);
    push_sample(dbf_pkg::ACT_CLEAR, 127);
    push_sample(dbf_pkg::ACT_FILTER, 64);
    push_sample(dbf_pkg::ACT_FILTER, 64);
    push_sample(dbf_pkg::ACT_FILTER, 65);

    // widest deadzone: bottom snap, hold below the margin, release, then top snap
    drain();
    set_reg(dbf_pkg::CFG_DEADZONE, 6'd63);
    push_sample(dbf_pkg::ACT_FILTER, 63);
    push_sample(dbf_pkg::ACT_FILTER, 64);
    push_sample(dbf_pkg::ACT_FILTER, 65);
    push_sample(dbf_pkg::ACT_FILTER, 64);

    // zero deadzone acts as one
    drain();
    set_reg(dbf_pkg::CFG_DEADZONE, 6'd0);
    push_sample(dbf_pkg::ACT_FILTER, 1);

    // snapping off and back on, and a repeated snap-on write with the end flag still set
    drain();
    set_reg(dbf_pkg::CFG_DEADZONE, 6'd10);
    set_reg(dbf_pkg::CFG_SNAP, 6'd0);
    push_sample(dbf_pkg::ACT_FILTER, 5);
    push_sample(dbf_pkg::ACT_FILTER, 127);
    push_sample(dbf_pkg::ACT_FILTER, 120);
    drain();
    set_reg(dbf_pkg::CFG_SNAP, 6'd1);
    push_sample(dbf_pkg::ACT_FILTER, 118);
    drain();
    set_reg(dbf_pkg::CFG_SNAP, 6'd1);
    push_sample(dbf_pkg::ACT_FILTER, 116);
    push_sample(dbf_pkg::ACT_FILTER, 115);
    push_sample(dbf_pkg::ACT_FILTER, 0);
    drain();
    set_reg(dbf_pkg::CFG_SNAP, 6'd0);
    set_reg(dbf_pkg::CFG_SNAP, 6'd1);
    push_sample(dbf_pkg::ACT_FILTER, 40);

    // random phases, each with its own register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      snap_data = 6'($urandom_range(0, 63));
      snap_data[0] = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        set_reg(dbf_pkg::CFG_DEADZONE, pick_deadzone());
        set_reg(dbf_pkg::CFG_SNAP, snap_data);
      end else begin
        set_reg(dbf_pkg::CFG_SNAP, snap_data);
        set_reg(dbf_pkg::CFG_DEADZONE, pick_deadzone());
      end
      quiet = (p == 5);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 3 && i == PHASE_WORDS / 2) drain();
        if ($urandom_range(0, 99) < 5)
          push_sample(dbf_pkg::ACT_CLEAR, $urandom_range(0, 127));
        else
          push_sample(dbf_pkg::ACT_FILTER, pick_sample());
      end
    end
    quiet = 1'b0;

    drain();
    repeat (6) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
